[rtl/hill_cipher_mod37_encrypt_unit_defines.svh]
// Assertion macros shared by the Hill cipher encryptor RTL.
`ifndef HILL_CIPHER_MOD37_ENCRYPT_UNIT_DEFINES_SVH
`define HILL_CIPHER_MOD37_ENCRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define HCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcm: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define HCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcm: next-cycle check failed");

`endif

[rtl/hcm_pkg.sv]
// Types, constants and symbol mapping functions of the Hill cipher encryptor.
package hcm_pkg;

  localparam int unsigned MAX_BLOCK   = 15;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned KEY_DEPTH   = MAX_BLOCK * MAX_BLOCK;
  localparam int unsigned KEY_ADDR_W  = 8;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned RECIP       = 56679;  // floor(2^21 / 37)
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [SYM_W-1:0]  SYM_COUNT = 6'd37;
  localparam logic [SYM_W-1:0]  SYM_SPACE = 6'd36;
  localparam logic [SYM_W-1:0]  SYM_DIGIT = 6'd26;

  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LAST,
    S_SCALE,
    S_EMIT
  } state_t;

  // Controls for the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic accum;
    logic scale;
  } mac_ctl_t;

  function automatic logic [SYM_W-1:0] to_symbol(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    logic [SYM_W-1:0]  s;
    s = '0;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      d = c - CHAR_A;
      s = d[SYM_W-1:0];
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
      s = d[SYM_W-1:0] + SYM_DIGIT;
    end else if (c == CHAR_SPACE) begin
      s = SYM_SPACE;
    end
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [SYM_W-1:0] s);
    logic [CHAR_W-1:0] c;
    if (s < SYM_DIGIT) begin
      c = CHAR_A + {2'b00, s};
    end else if (s < SYM_SPACE) begin
      c = CHAR_0 + {2'b00, s - SYM_DIGIT};
    end else begin
      c = CHAR_SPACE;
    end
    return c;
  endfunction

  // Row-major address of a key entry: row * 15 + col.
  function automatic logic [KEY_ADDR_W-1:0] key_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
    logic [KEY_ADDR_W-1:0] a;
    a = {row, 4'b0000} - {4'b0000, row} + {4'b0000, col};
    return a;
  endfunction

endpackage

[rtl/hcm_key_ram.sv]
// Key matrix storage: one write port, one registered read port.
module hcm_key_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [hcm_pkg::KEY_ADDR_W-1:0] wr_addr,
  input  logic [hcm_pkg::SYM_W-1:0]      wr_data,
  input  logic [hcm_pkg::KEY_ADDR_W-1:0] rd_addr,
  output logic [hcm_pkg::SYM_W-1:0]      rd_data
);
  import hcm_pkg::*;

  logic [SYM_W-1:0] mem [KEY_DEPTH];
  logic [SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hcm_mac.sv]
// Shared multiply-accumulate unit with reciprocal-based reduction mod 37.
module hcm_mac (
  input  logic                     clk,
  input  hcm_pkg::mac_ctl_t        ctl,
  input  logic [hcm_pkg::SYM_W-1:0] key_data,
  input  logic [hcm_pkg::SYM_W-1:0] sym_data,
  output logic [hcm_pkg::SYM_W-1:0] residue
);
  import hcm_pkg::*;

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [2*SYM_W-1:0]  term;
  logic [QUOT_W-1:0]   quot;
  logic [ACC_W-1:0]    quot_x37;
  logic [ACC_W-1:0]    diff;

  assign term = key_data * sym_data;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.accum) begin
      acc_nxt = acc_r + ACC_W'(term);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.scale) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(RECIP);
    end
  end

  // The estimated quotient is exact or one short, so one subtract corrects it.
  assign quot     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign quot_x37 = ACC_W'(quot) * ACC_W'(SYM_COUNT);
  assign diff     = acc_r - quot_x37;
  assign residue  = (diff >= ACC_W'(SYM_COUNT)) ? SYM_W'(diff - ACC_W'(SYM_COUNT))
                                                 : diff[SYM_W-1:0];

endmodule

[rtl/hill_cipher_mod37_encrypt_unit.sv]
// Top level of the Hill cipher encryptor over the 37-symbol alphabet.
// Input channel (in_valid / in_stall): each transfer is either a key entry
// (opcode 0) written to row key_row, column key_col, or a plaintext byte
// (opcode 1). Key transfers give no output. A plaintext
// byte is mapped to its symbol and buffered; once n symbols are held, or on
// end_of_message (the rest of the block padded with spaces), the block is
// encrypted and n ciphertext bytes leave on the output channel, the final
// one of a message flagged by out_last_of_message.
// Rate: one multiply-accumulate unit works through the key matrix one entry
// per cycle while fetching. Each ciphertext byte takes n products, a drain
// step for the registered key read, one scaling multiply, and one reduction
// and load, which waits while the output stalls. in_stall is high until the
// last byte of the block is loaded into the output register.
// Output channel (out_valid / out_stall): results sit in an output register;
// while the receiver stalls, the unit holds its next byte and waits.
// Configuration: cfg_wr_en writes cfg_wr_data as the block size n (0 acts
// as 1); write it only while the unit is idle.
// Reset (rst_n low, synchronous) empties the block buffer, drops any pending
// output and sets n to 1. Key entries are undefined until loaded.
`include "hill_cipher_mod37_encrypt_unit_defines.svh"

module hill_cipher_mod37_encrypt_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [hcm_pkg::IDX_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [hcm_pkg::IDX_W-1:0]  in_key_row,
  input  logic [hcm_pkg::IDX_W-1:0]  in_key_col,
  input  logic [hcm_pkg::SYM_W-1:0]  in_key_value,
  input  logic [hcm_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_end_of_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcm_pkg::CHAR_W-1:0] out_cipher_char,
  output logic                       out_last_of_message
);
  import hcm_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] block_size_r;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic             pad_r, pad_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic             out_last_r;

  logic [SYM_W-1:0] buf_r [MAX_BLOCK];
  logic [SYM_W-1:0] sym_d_r;
  logic [SYM_W-1:0] sym_sel;

  logic [IDX_W-1:0] n_act;
  logic [IDX_W-1:0] fill_inc;
  logic             in_xfer;
  logic             out_xfer;
  logic             out_load;
  logic             key_we;
  logic [SYM_W-1:0] key_rd_data;
  logic [SYM_W-1:0] residue;
  mac_ctl_t         mac_ctl;

  assign n_act    = (block_size_r == '0) ? IDX_W'(1) : block_size_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // The fill count saturates at 15 instead of wrapping to zero.
  assign fill_inc = (fill_r == IDX_W'(MAX_BLOCK)) ? IDX_W'(MAX_BLOCK) : fill_r + 1'b1;

  // Symbols past the fill point of a padded block read as spaces.
  assign sym_sel = (pad_r && col_r >= fill_r) ? SYM_SPACE : buf_r[col_r];

  assign key_we = in_xfer && (in_opcode == OP_KEY)
                  && (in_key_row < IDX_W'(MAX_BLOCK)) && (in_key_col < IDX_W'(MAX_BLOCK));

  hcm_key_ram u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_addr(in_key_row, in_key_col)),
    .wr_data (in_key_value),
    .rd_addr (key_addr(row_r, col_r)),
    .rd_data (key_rd_data)
  );

  hcm_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .key_data (key_rd_data),
    .sym_data (sym_d_r),
    .residue  (residue)
  );

  // Sequencer: walks rows and columns of the key matrix for one block.
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    fill_nxt  = fill_r;
    pad_nxt   = pad_r;
    last_nxt  = last_r;
    mac_ctl   = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_opcode == OP_CHAR) begin
          fill_nxt = fill_inc;
          if (fill_inc >= n_act || in_end_of_message) begin
            state_nxt     = S_FETCH;
            row_nxt       = '0;
            col_nxt       = '0;
            pad_nxt       = (fill_inc < n_act);
            last_nxt      = in_end_of_message;
            mac_ctl.clear = 1'b1;
          end
        end
      end
      S_FETCH: begin
        // Read data of the previous column arrives now.
        mac_ctl.accum = (col_r != '0);
        if (col_r == n_act - 1'b1) begin
          state_nxt = S_LAST;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_LAST: begin
        mac_ctl.accum = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        mac_ctl.scale = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          if (row_r == n_act - 1'b1) begin
            state_nxt = S_IDLE;
            fill_nxt  = '0;
          end else begin
            state_nxt     = S_FETCH;
            row_nxt       = row_r + 1'b1;
            col_nxt       = '0;
            mac_ctl.clear = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      block_size_r <= IDX_W'(1);
      row_r        <= '0;
      col_r        <= '0;
      fill_r       <= '0;
      pad_r        <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_r      <= fill_nxt;
      pad_r       <= pad_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        block_size_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: block buffer, delayed symbol, output byte and its last flag.
  always_ff @(posedge clk) begin
    if (in_xfer && in_opcode == OP_CHAR && fill_r < IDX_W'(MAX_BLOCK)) begin
      buf_r[fill_r] <= to_symbol(in_char_code);
    end
    sym_d_r <= sym_sel;
    if (out_load) begin
      out_char_r <= to_ascii(residue);
      out_last_r <= last_r && (row_r == n_act - 1'b1);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cipher_char     = out_char_r;
  assign out_last_of_message = out_last_r;

  `HCM_ASSERT_IMPL(a_fetch_in_range, state_r == S_FETCH, (col_r < n_act) && (row_r < n_act))
  `HCM_ASSERT_IMPL(a_residue_range, out_load, residue < SYM_COUNT)
  `HCM_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT)
  `HCM_ASSERT_NEXT(a_last_only_final, out_load && (row_r != n_act - 1'b1), !out_last_r)

endmodule
